@@ hw/rtl/virtual_hall_commutation_motion_fsm_top_defines.svh @@
// Assertion macros used by the checker file of the virtual Hall motion block.
`ifndef VIRTUAL_HALL_COMMUTATION_MOTION_FSM_TOP_DEFINES_SVH
`define VIRTUAL_HALL_COMMUTATION_MOTION_FSM_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VHCM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vhcm checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define VHCM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vhcm checker: next-cycle property failed");

`endif

@@ hw/rtl/vhcm_pkg.sv @@
package vhcm_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int REQ_DATA_BITS = ((3 * SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 11;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = SAMPLE_BITS;
   localparam int REL_BITS = SAMPLE_BITS + 3;
   localparam int RELEASE_NUM = 5;
   localparam int RELEASE_DEN = 4;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE        = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXT_START   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLEX_START  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXT_STOP    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLEX_STOP   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FULL_EXT    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FULL_FLEX   = 3'd6;

   localparam logic [1:0] MODE_FOLLOW       = 2'd0;
   localparam logic [1:0] MODE_WAIT_RELEASE = 2'd1;

   localparam logic [1:0] MS_IDLE_CODE = 2'd0;
   localparam logic [1:0] MS_EXT_CODE  = 2'd1;
   localparam logic [1:0] MS_FLEX_CODE = 2'd2;
   localparam logic [1:0] MS_WAIT_CODE = 2'd3;

   localparam logic [1:0] ZONE_NONE      = 2'd0;
   localparam logic [1:0] ZONE_FULL_EXT  = 2'd1;
   localparam logic [1:0] ZONE_FULL_FLEX = 2'd2;

   localparam logic [2:0] EVT_NONE       = 3'd0;
   localparam logic [2:0] EVT_EXT_START  = 3'd1;
   localparam logic [2:0] EVT_FLEX_START = 3'd2;
   localparam logic [2:0] EVT_EXT_STOP   = 3'd3;
   localparam logic [2:0] EVT_FLEX_STOP  = 3'd4;

   localparam logic [2:0] HALL_FIRST = 3'd0;
   localparam logic [2:0] HALL_LAST  = 3'd5;

   localparam sample_type THRESH_RESET    = sample_type'(2048);
   localparam sample_type FULL_EXT_RESET  = '0;
   localparam sample_type FULL_FLEX_RESET = '1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXT  = 4'b0010,
      ST_FLEX = 4'b0100,
      ST_WAIT = 4'b1000
   } motion_state_type;

   typedef struct packed {
      logic [1:0] mode;
      sample_type ext_start;
      sample_type flex_start;
      sample_type ext_stop;
      sample_type flex_stop;
      sample_type full_ext;
      sample_type full_flex;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      mode:       MODE_FOLLOW,
      ext_start:  THRESH_RESET,
      flex_start: THRESH_RESET,
      ext_stop:   THRESH_RESET,
      flex_stop:  THRESH_RESET,
      full_ext:   FULL_EXT_RESET,
      full_flex:  FULL_FLEX_RESET
   };

   typedef struct packed {
      logic       op;
      sample_type front;
      sample_type back;
      sample_type angle;
   } req_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [1:0] limit_zone;
      logic [2:0] hall_pattern;
      logic       motor_enable;
      logic [1:0] motion_state;
   } rsp_type;

   function automatic logic [2:0] hall_pattern_of(input logic [2:0] step);
      logic [2:0] pat;
      case (step)
         3'd0:    pat = 3'd1;
         3'd1:    pat = 3'd3;
         3'd2:    pat = 3'd2;
         3'd3:    pat = 3'd6;
         3'd4:    pat = 3'd4;
         3'd5:    pat = 3'd5;
         default: pat = 3'd1;
      endcase
      return pat;
   endfunction

   function automatic logic [1:0] state_code(input motion_state_type st);
      logic [1:0] code;
      unique case (st)
         ST_IDLE: code = MS_IDLE_CODE;
         ST_EXT:  code = MS_EXT_CODE;
         ST_FLEX: code = MS_FLEX_CODE;
         ST_WAIT: code = MS_WAIT_CODE;
         default: code = MS_IDLE_CODE;
      endcase
      return code;
   endfunction

endpackage

@@ hw/rtl/vhcm_cfg_regs.sv @@
module vhcm_cfg_regs (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [vhcm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [vhcm_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output vhcm_pkg::cfg_type                     cfg
);
   import vhcm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      unique case (csr_index)
         CSR_MODE:       cfg_in.mode       = csr_wdata[1:0];
         CSR_EXT_START:  cfg_in.ext_start  = sample_type'(csr_wdata);
         CSR_FLEX_START: cfg_in.flex_start = sample_type'(csr_wdata);
         CSR_EXT_STOP:   cfg_in.ext_stop   = sample_type'(csr_wdata);
         CSR_FLEX_STOP:  cfg_in.flex_stop  = sample_type'(csr_wdata);
         CSR_FULL_EXT:   cfg_in.full_ext   = sample_type'(csr_wdata);
         CSR_FULL_FLEX:  cfg_in.full_flex  = sample_type'(csr_wdata);
         default:        cfg_in = cfg_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wen) begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/vhcm_motion_core.sv @@
module vhcm_motion_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  vhcm_pkg::req_type item,
   input  vhcm_pkg::cfg_type cfg,
   output vhcm_pkg::rsp_type result
);
   import vhcm_pkg::*;

   motion_state_type state_ff;
   motion_state_type state_in;
   logic [2:0]       hall_ff;
   logic [2:0]       hall_in;
   logic             motor_ff;
   logic             motor_in;

   logic [1:0]          zone;
   logic                ext_go;
   logic                flex_go;
   logic                ext_halt;
   logic                flex_halt;
   logic                halt_ext;
   logic                halt_flex;
   logic                released;
   logic                try_start;
   logic [2:0]          hall_fwd;
   logic [2:0]          hall_bwd;
   logic [2:0]          event_code;
   logic [REL_BITS-1:0] front_x5;
   logic [REL_BITS-1:0] back_x5;
   logic [REL_BITS-1:0] ext_start_x4;
   logic [REL_BITS-1:0] flex_start_x4;

   always_comb begin
      if (item.angle < cfg.full_ext) begin
         zone = ZONE_FULL_EXT;
      end else if (item.angle > cfg.full_flex) begin
         zone = ZONE_FULL_FLEX;
      end else begin
         zone = ZONE_NONE;
      end
   end

   assign ext_go    = (item.front > cfg.ext_start) && (zone != ZONE_FULL_EXT);
   assign flex_go   = (item.back > cfg.flex_start) && (zone != ZONE_FULL_FLEX);
   assign ext_halt  = (item.back > cfg.ext_stop) || (zone == ZONE_FULL_EXT);
   assign flex_halt = (item.front > cfg.flex_stop) || (zone == ZONE_FULL_FLEX);
   assign halt_ext  = (cfg.mode == MODE_FOLLOW) ? !ext_go : ext_halt;
   assign halt_flex = (cfg.mode == MODE_FOLLOW) ? !flex_go : flex_halt;

   // The release level of 0.8 of the start threshold is compared in whole numbers.
   assign front_x5      = REL_BITS'(item.front) * REL_BITS'(RELEASE_NUM);
   assign back_x5       = REL_BITS'(item.back) * REL_BITS'(RELEASE_NUM);
   assign ext_start_x4  = REL_BITS'(cfg.ext_start) * REL_BITS'(RELEASE_DEN);
   assign flex_start_x4 = REL_BITS'(cfg.flex_start) * REL_BITS'(RELEASE_DEN);
   assign released      = (front_x5 < ext_start_x4) && (back_x5 < flex_start_x4);

   assign hall_fwd = (hall_ff >= HALL_LAST) ? HALL_FIRST : hall_ff + 3'd1;
   assign hall_bwd = (hall_ff == HALL_FIRST) ? HALL_LAST : hall_ff - 3'd1;

   always_comb begin
      state_in   = state_ff;
      hall_in    = hall_ff;
      motor_in   = motor_ff;
      event_code = EVT_NONE;
      try_start  = 1'b0;
      if (item.op) begin
         motor_in = 1'b0;
         hall_in  = HALL_FIRST;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               try_start = 1'b1;
            end
            ST_WAIT: begin
               if (cfg.mode == MODE_FOLLOW) begin
                  try_start = 1'b1;
               end else if (released) begin
                  state_in = ST_IDLE;
               end
            end
            ST_EXT: begin
               if (halt_ext) begin
                  state_in   = (cfg.mode == MODE_WAIT_RELEASE) ? ST_WAIT : ST_IDLE;
                  motor_in   = 1'b0;
                  event_code = EVT_EXT_STOP;
               end else begin
                  hall_in  = hall_fwd;
                  motor_in = 1'b1;
               end
            end
            ST_FLEX: begin
               if (halt_flex) begin
                  state_in   = (cfg.mode == MODE_WAIT_RELEASE) ? ST_WAIT : ST_IDLE;
                  motor_in   = 1'b0;
                  event_code = EVT_FLEX_STOP;
               end else begin
                  hall_in  = hall_bwd;
                  motor_in = 1'b1;
               end
            end
            default: state_in = ST_IDLE;
         endcase
         if (try_start) begin
            if (ext_go) begin
               state_in   = ST_EXT;
               hall_in    = hall_fwd;
               motor_in   = 1'b1;
               event_code = EVT_EXT_START;
            end else if (flex_go) begin
               state_in   = ST_FLEX;
               hall_in    = hall_bwd;
               motor_in   = 1'b1;
               event_code = EVT_FLEX_START;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hall_ff  <= HALL_FIRST;
         motor_ff <= 1'b0;
      end else if (step_en) begin
         state_ff <= state_in;
         hall_ff  <= hall_in;
         motor_ff <= motor_in;
      end
   end

   assign result.motion_state = state_code(state_in);
   assign result.motor_enable = motor_in;
   assign result.hall_pattern = hall_pattern_of(hall_in);
   assign result.limit_zone   = zone;
   assign result.event_res    = event_code;

endmodule

@@ hw/rtl/virtual_hall_commutation_motion_fsm_top.sv @@
// Motion state machine for a powered joint with a six-step virtual Hall commutation output.
// Each req_ transaction carries one control tick (or an emergency stop) and yields exactly
// one rsp_ transaction. The block takes one transaction in every clock cycle unless rsp_
// back-pressure stalls it; a transaction is held in the input register, where the zone,
// trigger and Hall stepping logic updates the machine state and the result register is
// loaded, and the result register drives rsp_. Back-pressure on rsp_ stalls both registers.
// Configuration writes on csr_ take effect at the next clock edge and are meant to be made
// while no transaction is in flight.
module virtual_hall_commutation_motion_fsm_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // From bit 0: front_force, back_force, angle_sample, zero fill.
   input  logic [vhcm_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // Bit 0: op.
   input  logic [0:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // From bit 0: motion_state, motor_enable, hall_pattern, limit_zone, event_res, zero fill.
   output logic [vhcm_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                 csr_wen,
   input  logic [vhcm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [vhcm_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import vhcm_pkg::*;

   cfg_type cfg;
   req_type req_item;
   rsp_type step_result;

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_item_ff;
   logic    out_free;
   logic    step_en;

   vhcm_cfg_regs u_cfg_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign req_item.op    = req_tuser[0];
   assign req_item.front = req_tdata[SAMPLE_BITS-1:0];
   assign req_item.back  = req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign req_item.angle = req_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

   assign out_free    = !out_valid_ff || rsp_tready;
   assign req_tready  = !in_valid_ff || out_free;
   assign step_en     = in_valid_ff && out_free;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_item;
      end
      if (step_en) begin
         out_item_ff <= step_result;
      end
   end

   vhcm_motion_core u_motion_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS - RSP_FIELD_BITS){1'b0}}, out_item_ff};

endmodule

@@ hw/rtl/vhcm_checker.sv @@
`include "virtual_hall_commutation_motion_fsm_top_defines.svh"

module vhcm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [vhcm_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);
   import vhcm_pkg::*;

   rsp_type rsp_view;
   logic    rsp_stall;
   logic    rsp_moving;
   logic    rsp_start;
   logic    rsp_motor;

   assign rsp_view   = rsp_type'(rsp_tdata[RSP_FIELD_BITS-1:0]);
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_motor  = rsp_tvalid && rsp_view.motor_enable;
   assign rsp_moving = (rsp_view.motion_state == MS_EXT_CODE) ||
                       (rsp_view.motion_state == MS_FLEX_CODE);
   assign rsp_start  = rsp_tvalid && ((rsp_view.event_res == EVT_EXT_START) ||
                                      (rsp_view.event_res == EVT_FLEX_START));

   // A stalled result must hold until it is taken.
   `VHCM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // No result may be offered in the cycle after reset.
   `VHCM_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

   // The motor is only driven while extending or flexing.
   `VHCM_ASSERT_SAME(a_motor_moving, clock, reset, rsp_motor, rsp_moving)

   // A start transaction always enables the motor.
   `VHCM_ASSERT_SAME(a_start_enables, clock, reset, rsp_start, rsp_view.motor_enable)

endmodule

bind virtual_hall_commutation_motion_fsm_top vhcm_checker u_vhcm_checker (.*);
